// ===== hdl/gnm_pkg.sv =====
// Shared types, codes and widths of the greedy nearest matching block.
package gnm_pkg;

  localparam int OP_W               = 2;
  localparam int ST_W               = 2;
  localparam int IDX_OUT_W          = 6;
  localparam int DIST_W             = 52;
  localparam int DEFAULT_MAX_POINTS = 64;
  localparam int DEFAULT_COORD_BITS = 24;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [DIST_W-1:0] dist_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_QUERY = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam dist_t DIST_MAX = '1;

endpackage

// ===== hdl/greedy_nearest_matching.sv =====
// Top level of the greedy nearest matching block: target store, distance walk, result register.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    opcode, point_x, point_y, point_z
//   out_     output     out_valid / out_ready  status, match_index, match_dist2
//
// A load, a clear or an unused opcode goes from the idle state straight to the done state.
// A query first walks every stored target, skipping the taken ones. One subtract and square
// unit is walked over the x, y and z axis of each free target, read from the store RAM.
// Synchronous reset empties the store count and the taken marks and drops any waiting result.
// The store RAM itself is not cleared, since only slots written since the last clear are read.
// A stalled out_ready holds the result in the output register. The next request is still
// accepted, and its result then waits in the done state, with in_ready low, until the register
// drains.
module greedy_nearest_matching #(
  parameter int MAX_POINTS = gnm_pkg::DEFAULT_MAX_POINTS,
  parameter int COORD_BITS = gnm_pkg::DEFAULT_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gnm_pkg::op_t                 in_opcode,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gnm_pkg::status_t             out_status,
  output logic [gnm_pkg::IDX_OUT_W-1:0] out_match_index,
  output gnm_pkg::dist_t               out_match_dist2
);

  import gnm_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int IW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int EXT_W  = (PROD_W > DIST_W) ? PROD_W : DIST_W + 1;
  localparam int RAM_W  = 3 * COORD_BITS;

  // Sequencer states. A query walks RD -> MX -> MY -> MZ -> CMP for every free target.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MX   = 3'd2;
  localparam logic [2:0] S_MY   = 3'd3;
  localparam logic [2:0] S_MZ   = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         j_r, j_nxt;
  logic [MAX_POINTS-1:0] taken_r, taken_nxt;
  logic                  found_r, found_nxt;
  dist_t                 best_r, best_nxt;
  logic [IW-1:0]         best_j_r, best_j_nxt;
  status_t               status_r, status_nxt;
  dist_t                 acc_r, acc_nxt;
  dist_t                 prod_r, prod_nxt;
  logic [C-1:0]          qx_r, qx_nxt;
  logic [C-1:0]          qy_r, qy_nxt;
  logic [C-1:0]          qz_r, qz_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [IDX_OUT_W-1:0]  out_idx_r, out_idx_nxt;
  dist_t                 out_dist_r, out_dist_nxt;

  logic                  in_acc;
  logic                  ram_we, ram_re;
  logic [RAM_W-1:0]      ram_rdata;

  logic [C-1:0]          q_sel, t_sel;
  logic signed [C:0]     diff;
  logic [C:0]            neg;
  logic [C-1:0]          mag;
  logic [PROD_W-1:0]     prod;
  logic [EXT_W-1:0]      prod_ext;
  dist_t                 prod_sat;
  dist_t                 dist_now;

  // Adds two distances, clamping at the largest representable value.
  function automatic dist_t sat_add(input dist_t a, input dist_t b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Loads write the next free slot directly at acceptance.
  assign ram_we = in_acc && (in_opcode == OP_LOAD) && (count_r < CW'(MAX_POINTS));

  gnm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata ({in_point_x, in_point_y, in_point_z}),
    .re    (ram_re),
    .raddr (j_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // The shared unit: one axis difference, its magnitude and its square per cycle.
  always_comb begin
    case (state_r)
      S_MX: begin
        q_sel = qx_r;
        t_sel = ram_rdata[3*C-1:2*C];
      end
      S_MY: begin
        q_sel = qy_r;
        t_sel = ram_rdata[2*C-1:C];
      end
      default: begin
        q_sel = qz_r;
        t_sel = ram_rdata[C-1:0];
      end
    endcase
  end

  assign diff     = $signed({q_sel[C-1], q_sel}) - $signed({t_sel[C-1], t_sel});
  assign neg      = -diff;
  assign mag      = diff[C] ? neg[C-1:0] : diff[C-1:0];
  assign prod     = PROD_W'(mag) * PROD_W'(mag);
  assign prod_ext = EXT_W'(prod);
  assign prod_sat = (prod_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : prod_ext[DIST_W-1:0];
  assign dist_now = sat_add(acc_r, prod_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    j_nxt          = j_r;
    taken_nxt      = taken_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_j_nxt     = best_j_r;
    status_nxt     = status_r;
    acc_nxt        = acc_r;
    prod_nxt       = prod_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    qz_nxt         = qz_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_dist_nxt   = out_dist_r;
    ram_re         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ST_OK;
          best_nxt   = '0;
          best_j_nxt = '0;
          found_nxt  = 1'b0;
          j_nxt      = '0;
          qx_nxt     = in_point_x;
          qy_nxt     = in_point_y;
          qz_nxt     = in_point_z;
          state_nxt  = S_DONE;
          case (in_opcode)
            OP_LOAD: begin
              if (count_r < CW'(MAX_POINTS)) begin
                best_j_nxt = count_r[IW-1:0];
                count_nxt  = count_r + 1'b1;
              end else begin
                status_nxt = ST_FULL;
              end
            end
            OP_QUERY: begin
              state_nxt = S_RD;
            end
            OP_CLEAR: begin
              count_nxt = '0;
              taken_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (j_r == count_r) begin
          // End of the walk: claim the winner or report that nothing was free.
          state_nxt = S_DONE;
          if (found_r) begin
            taken_nxt[best_j_r] = 1'b1;
          end else begin
            status_nxt = ST_EMPTY;
          end
        end else if (taken_r[j_r[IW-1:0]]) begin
          j_nxt = j_r + 1'b1;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        prod_nxt  = prod_sat;
        state_nxt = S_MY;
      end
      S_MY: begin
        acc_nxt   = prod_r;
        prod_nxt  = prod_sat;
        state_nxt = S_MZ;
      end
      S_MZ: begin
        acc_nxt   = sat_add(acc_r, prod_r);
        prod_nxt  = prod_sat;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // Ties go to the later slot, so equal distances replace the best.
        if (!found_r || (dist_now <= best_r)) begin
          found_nxt  = 1'b1;
          best_nxt   = dist_now;
          best_j_nxt = j_r[IW-1:0];
        end
        j_nxt     = j_r + 1'b1;
        state_nxt = S_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_idx_nxt    = (status_r == ST_OK) ? IDX_OUT_W'(best_j_r) : '0;
          out_dist_nxt   = (status_r == ST_OK) ? best_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r       <= best_nxt;
    best_j_r     <= best_j_nxt;
    status_r     <= status_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    qz_r         <= qz_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_index = out_idx_r;
  assign out_match_dist2 = out_dist_r;

`ifndef SYNTH
  // Every accepted request takes the block out of idle, so in_ready drops and requests are never taken back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request accepted back to back");

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("stored count beyond store depth");

  // The walk pointer never runs past the filled part of the store.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    j_r <= count_r)
    else $error("walk pointer beyond stored count");

  // Only stored targets can be marked as taken.
  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(taken_r) <= count_r)
    else $error("more taken marks than stored targets");
`endif

endmodule

// ===== hdl/gnm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module gnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
